// ----- rtl/bbtc_pkg.sv -----
// Package: constants, request and status codes, and controller/datapath interface types.
`default_nettype none
package bbtc_pkg;
    localparam int MAX_BLOCKS  = 64;
    localparam int MAX_THREADS = 256;
    localparam int WARP_LANES  = 32;
    localparam int COUNT_BITS  = 32;
    localparam int SLOT_W      = 6;
    localparam int TID_W       = 8;
    localparam int LANE_W      = 5;
    localparam int ADDR_W      = SLOT_W + TID_W;
    localparam int DEPTH       = MAX_BLOCKS * MAX_THREADS;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_EVENT = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_SKIPPED = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [1:0] CFG_GRID_W  = 2'd0;
    localparam logic [1:0] CFG_GRID_H  = 2'd1;
    localparam logic [1:0] CFG_TPC     = 2'd2;
    localparam logic [1:0] CFG_BLOCKS  = 2'd3;

    typedef struct packed {
        logic latch;      // capture the request
        logic scan_step;  // move on to the next table slot
        logic base_mul1;  // first product stage
        logic base_mul2;  // second product stage
        logic base_mul3;  // third product stage
        logic lane_rd;    // issue counter read for current lane
        logic lane_wr;    // write back incremented counter
        logic clr_wr;     // write zero at sweep address
        logic rd_issue;   // issue read for a read request
        logic load_wr;    // write table entry
        logic done;       // present result
    } ctrl_t;

    typedef struct packed {
        logic scan_end;
        logic found;
        logic at_start;
        logic lane_last;
        logic clr_last;
        logic [1:0] req;
    } stat_t;
endpackage
`default_nettype wire

// ----- rtl/bbtc_ctrl.sv -----
// Controller state machine sequencing each request through the datapath.
`default_nettype none
module bbtc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire bbtc_pkg::stat_t st,
    output bbtc_pkg::ctrl_t     cmd
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_SRD, S_SCAN, S_MUL1, S_MUL2, S_MUL3, S_LRD,
        S_LWAIT, S_LWR, S_CLR, S_RD, S_RWAIT, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            // The counter memory is swept to zero once after reset.
            S_INIT:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.req)
                    bbtc_pkg::REQ_LOAD:
                    begin
                        cmd.load_wr = 1'b1;
                        state_next = S_DONE;
                    end
                    bbtc_pkg::REQ_EVENT: state_next = S_SCAN;
                    bbtc_pkg::REQ_READ:  state_next = S_RD;
                    default:             state_next = S_CLR;
                endcase
            end
            // Table data for the new slot is registered, so it arrives in the cycle after the slot moves.
            S_SRD: state_next = S_SCAN;
            S_SCAN:
            begin
                if (st.found || st.scan_end)
                    state_next = (st.found && st.at_start) ? S_MUL1 : S_DONE;
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_MUL1:
            begin
                cmd.base_mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.base_mul2 = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.base_mul3 = 1'b1;
                state_next = S_LRD;
            end
            S_LRD:
            begin
                cmd.lane_rd = 1'b1;
                state_next = S_LWAIT;
            end
            S_LWAIT: state_next = S_LWR;
            S_LWR:
            begin
                cmd.lane_wr = 1'b1;
                state_next = st.lane_last ? S_DONE : S_LRD;
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                    state_next = S_DONE;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// ----- rtl/bbtc_datapath.sv -----
// Datapath: block range table, counter memory, address arithmetic and result registers.
`default_nettype none
module bbtc_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bbtc_pkg::ctrl_t       cmd,
    output bbtc_pkg::stat_t            st,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,
    input  wire logic [1:0]            req_type,
    input  wire logic [5:0]            bb_slot,
    input  wire logic [31:0]           range_first_pc,
    input  wire logic [31:0]           range_last_pc,
    input  wire logic [31:0]           event_pc,
    input  wire logic [15:0]           cta_x,
    input  wire logic [15:0]           cta_y,
    input  wire logic [15:0]           cta_z,
    input  wire logic [31:0]           lane_mask,
    input  wire logic [13:0]           thread_slot,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [31:0]                count_value,
    output logic [5:0]                 hit_block
);
    localparam int AW = bbtc_pkg::ADDR_W;
    localparam int SW = bbtc_pkg::SLOT_W;
    localparam int LW = bbtc_pkg::LANE_W;

    logic [15:0] gw_reg, gh_reg;
    logic [10:0] tpc_reg;
    logic [6:0]  biu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= 16'd1;
            gh_reg  <= 16'd1;
            tpc_reg <= 11'd1;
            biu_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbtc_pkg::CFG_GRID_W: gw_reg  <= cfg_data;
                bbtc_pkg::CFG_GRID_H: gh_reg  <= cfg_data;
                bbtc_pkg::CFG_TPC:    tpc_reg <= cfg_data[10:0];
                default:              biu_reg <= cfg_data[6:0];
            endcase
        end
    end

    // Captured request word.
    logic [1:0]  req_reg;
    logic [5:0]  slot_reg;
    logic [31:0] fpc_reg, lpc_reg, pc_reg, mask_reg;
    logic [15:0] cx_reg, cy_reg, cz_reg;
    logic [13:0] tslot_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type; slot_reg <= bb_slot;
            fpc_reg <= range_first_pc; lpc_reg <= range_last_pc;
            pc_reg <= event_pc; mask_reg <= lane_mask;
            cx_reg <= cta_x; cy_reg <= cta_y; cz_reg <= cta_z;
            tslot_reg <= thread_slot;
        end
    end

    logic [6:0] scan_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            scan_reg <= '0;
        else if (cmd.scan_step)
            scan_reg <= scan_reg + 7'd1;
    end

    // Range table: small memories with a registered read at the scan slot.
    logic [31:0] tf_mem [bbtc_pkg::MAX_BLOCKS];
    logic [31:0] tl_mem [bbtc_pkg::MAX_BLOCKS];
    logic [31:0] tf_rd_reg, tl_rd_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            tf_mem[slot_reg] <= fpc_reg;
            tl_mem[slot_reg] <= lpc_reg;
        end
        tf_rd_reg <= tf_mem[scan_reg[SW-1:0]];
        tl_rd_reg <= tl_mem[scan_reg[SW-1:0]];
    end

    logic [6:0] limit;
    logic       hit_now;
    assign limit   = (biu_reg > 7'd64) ? 7'd64 : biu_reg;
    assign hit_now = (scan_reg < limit) && (tf_rd_reg <= pc_reg) && (pc_reg <= tl_rd_reg);

    // Thread base, three registered product stages.
    logic [31:0] ywide_reg, gwh_reg;
    logic [48:0] cta_reg;
    logic [48:0] base_reg;
    logic [33:0] cta_sum;
    logic [47:0] cz_term;
    assign cz_term = cz_reg * gwh_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.base_mul1)
        begin
            ywide_reg <= cy_reg * gw_reg;
            gwh_reg   <= gw_reg * gh_reg;
        end
    end
    assign cta_sum = 34'(cx_reg) + 34'(ywide_reg);
    logic [48:0] cta_full;
    assign cta_full = 49'(cz_term) + 49'(cta_sum);
    always_ff @(posedge clk)
    begin
        if (cmd.base_mul2)
            cta_reg <= cta_full;
    end
    logic [59:0] base_full;
    assign base_full = cta_reg * tpc_reg;
    logic big_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.base_mul3)
        begin
            base_reg <= base_full[48:0];
            big_reg  <= |base_full[59:49];
        end
    end

    // Lane walk: one read-modify-write per lane.
    logic [LW-1:0] lane_reg;
    logic          skip_reg;
    logic [49:0]   tid;
    logic          lane_ok;
    logic          lane_on;
    assign tid     = 50'(base_reg) + 50'(lane_reg);
    assign lane_on = mask_reg[lane_reg];
    assign lane_ok = !big_reg && (tid < 50'(bbtc_pkg::MAX_THREADS));
    always_ff @(posedge clk)
    begin
        if (cmd.base_mul2)
        begin
            lane_reg <= '0;
            skip_reg <= 1'b0;
        end
        else if (cmd.lane_wr)
        begin
            lane_reg <= lane_reg + LW'(1);
            if (lane_on && !lane_ok)
                skip_reg <= 1'b1;
        end
    end

    logic [AW-1:0] clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_wr)
            clr_reg <= clr_reg + AW'(1);
    end

    // Counter memory, one write port and one read port, registered read.
    logic [31:0]   mem [bbtc_pkg::DEPTH];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] laddr, raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    assign laddr = {scan_reg[SW-1:0], tid[bbtc_pkg::TID_W-1:0]};
    assign raddr = cmd.rd_issue ? {slot_reg, tslot_reg[bbtc_pkg::TID_W-1:0]} : laddr;
    assign we    = cmd.clr_wr || (cmd.lane_wr && lane_on && lane_ok);
    assign waddr = cmd.clr_wr ? clr_reg : laddr;
    assign wdata = cmd.clr_wr ? 32'd0 : ((&rdata_reg) ? rdata_reg : rdata_reg + 32'd1);
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    logic rd_ok;
    assign rd_ok = (tslot_reg < 14'(bbtc_pkg::MAX_THREADS));

    always_comb
    begin
        st.scan_end  = (scan_reg >= limit);
        st.found     = hit_now;
        st.at_start  = (tf_rd_reg == pc_reg);
        st.lane_last = (lane_reg == LW'(bbtc_pkg::WARP_LANES - 1));
        st.clr_last  = (&clr_reg);
        st.req       = req_reg;
    end

    // Result register, shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= cmd.done;
    end
    always_ff @(posedge clk)
    begin
        if (cmd.done)
        begin
            status <= bbtc_pkg::ST_DONE; count_value <= '0; hit_block <= '0;
            case (req_reg)
                bbtc_pkg::REQ_EVENT:
                begin
                    if (!(scan_reg < limit))
                        status <= bbtc_pkg::ST_IGNORED;
                    else
                    begin
                        hit_block <= scan_reg[SW-1:0];
                        if (tf_rd_reg != pc_reg)
                            status <= bbtc_pkg::ST_IGNORED;
                        else if (skip_reg)
                            status <= bbtc_pkg::ST_SKIPPED;
                    end
                end
                bbtc_pkg::REQ_READ:
                begin
                    if (rd_ok)
                        count_value <= rdata_reg;
                    else
                        status <= bbtc_pkg::ST_BAD;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/basic_block_thread_counter.sv -----
// Top level: per-thread basic block visit counter.
// An event searches the table slots in order and stops at the first match; only a PC
// at the start of the matched block walks the warp lanes. The next start is taken at
// the edge on which the receiver takes the result.
// Results appear for one cycle with done; the receiver cannot stall.
// Reset: configuration and control registers return to defaults; busy then stays high while counters clear.
`default_nettype none
module basic_block_thread_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [1:0]  req_type,
    input  wire logic [5:0]  bb_slot,
    input  wire logic [31:0] range_first_pc,
    input  wire logic [31:0] range_last_pc,
    input  wire logic [31:0] event_pc,
    input  wire logic [15:0] cta_x,
    input  wire logic [15:0] cta_y,
    input  wire logic [15:0] cta_z,
    input  wire logic [31:0] lane_mask,
    input  wire logic [13:0] thread_slot,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      count_value,
    output logic [5:0]       hit_block
);
    bbtc_pkg::ctrl_t cmd;
    bbtc_pkg::stat_t st;

    bbtc_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .st, .cmd);
    bbtc_datapath u_dp (.clk, .rst_n, .cmd, .st, .cfg_we, .cfg_index, .cfg_data,
        .req_type, .bb_slot, .range_first_pc, .range_last_pc, .event_pc,
        .cta_x, .cta_y, .cta_z, .lane_mask, .thread_slot,
        .done, .status, .count_value, .hit_block);

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |-> busy) else $error("result outside a request");
    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bbtc_pkg::ST_BAD) |-> (hit_block == 6'd0))
        else $error("hit on bad index");
endmodule
`default_nettype wire
